// ===== rtl/rcl_pkg.sv =====
// Shared constants, types and the color wheel function for the rainbow cycle generator.
package rcl_pkg;

	localparam int PIXELS = 16;

	localparam int TS_W    = 32;
	localparam int WAIT_W  = 8;
	localparam int HUE_W   = 8;
	localparam int IDX_W   = 6;
	localparam int COLOR_W = 24;
	localparam int CHAN_W  = 8;

	localparam int PIX_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;

	localparam logic [WAIT_W-1:0] FRAME_WAIT_RST = WAIT_W'(10);

	// Wheel base of pixel i is floor(i*256/PIXELS); walk it with a step and a remainder.
	localparam int WHEEL_SPAN = 256;
	localparam int BASE_STEP  = WHEEL_SPAN / PIXELS;
	localparam int BASE_REM   = WHEEL_SPAN % PIXELS;
	localparam int REM_W      = $clog2(2 * PIXELS + 1);

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = 1;
	localparam int CMDQ_CNT_W = 2;

	localparam logic [CHAN_W-1:0] WHEEL_SEG1 = CHAN_W'(85);
	localparam logic [CHAN_W-1:0] WHEEL_SEG2 = CHAN_W'(170);
	localparam logic [CHAN_W-1:0] CHAN_MAX   = CHAN_W'(255);

	typedef logic [HUE_W-1:0] hue_t;

	// Frame command handed from the front to the back through the queue.
	typedef struct packed {
		logic push;
		hue_t hue;
	} frame_cmd_t;

	function automatic logic [CHAN_W-1:0] times3(input logic [CHAN_W-1:0] v);
		logic [CHAN_W+1:0] s;
		s = {2'b00, v} + {1'b0, v, 1'b0};
		return s[CHAN_W-1:0];
	endfunction

	function automatic logic [COLOR_W-1:0] wheel_grb(input logic [CHAN_W-1:0] pos);
		logic [CHAN_W-1:0] p;
		logic [CHAN_W-1:0] q3;
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
		p = CHAN_MAX - pos;
		if (p < WHEEL_SEG1) begin
			q3 = times3(p);
			r  = CHAN_MAX - q3;
			g  = '0;
			b  = q3;
		end else if (p < WHEEL_SEG2) begin
			q3 = times3(p - WHEEL_SEG1);
			r  = '0;
			g  = q3;
			b  = CHAN_MAX - q3;
		end else begin
			q3 = times3(p - WHEEL_SEG2);
			r  = q3;
			g  = CHAN_MAX - q3;
			b  = '0;
		end
		return {g, r, b};
	endfunction

endpackage

// ===== rtl/rcl_front.sv =====
// Front end: tick compare, hue advance and next update time.
module rcl_front import rcl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [TS_W-1:0]   timestamp,
	input  logic              cfg_write,
	input  logic [WAIT_W-1:0] cfg_wait,
	output frame_cmd_t        cmd
);

	logic              started_q;
	hue_t              hue_q;
	logic [TS_W-1:0]   next_time_q;
	logic [WAIT_W-1:0] frame_wait_q;
	logic              update;
	hue_t              hue_next;

	assign update   = accept && started_q && (timestamp > next_time_q);
	assign hue_next = hue_q + HUE_W'(1);

	assign cmd.push = update;
	assign cmd.hue  = hue_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			hue_q        <= '0;
			next_time_q  <= '0;
			frame_wait_q <= FRAME_WAIT_RST;
		end else begin
			if (cfg_write) begin
				frame_wait_q <= cfg_wait;
			end
			// First tick only arms the timer.
			if (accept && !started_q) begin
				started_q   <= 1'b1;
				next_time_q <= timestamp;
			end else if (update) begin
				hue_q       <= hue_next;
				next_time_q <= timestamp + TS_W'(frame_wait_q);
			end
		end
	end

endmodule

// ===== rtl/rcl_cmdq.sv =====
// Small queue of frame commands between front and back.
module rcl_cmdq import rcl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  frame_cmd_t wr,
	input  logic       pop,
	output logic       full,
	output logic       empty,
	output hue_t       head_hue
);

	hue_t                  mem_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full     = (count_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign empty    = (count_q == '0);
	assign head_hue = mem_q[rd_ptr_q];
	assign do_push  = wr.push && !full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr.hue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + CMDQ_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + CMDQ_PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CMDQ_CNT_W'(1);
				2'b01:   count_q <= count_q - CMDQ_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/rcl_back.sv =====
// Back end: walk the pixels of one frame and hold each color in the output register.
module rcl_back import rcl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_empty,
	input  hue_t               cmd_hue,
	output logic               cmd_pop,
	output logic               empty,
	input  logic               pop,
	output logic [IDX_W-1:0]   pixel_index,
	output logic [COLOR_W-1:0] grb_color,
	output logic               frame_last
);

	logic               active_q;
	hue_t               hue_q;
	logic [PIX_W-1:0]   pix_q;
	logic [CHAN_W-1:0]  base_q;
	logic [REM_W-1:0]   rem_q;
	logic               out_valid_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic [COLOR_W-1:0] out_color_q;
	logic               out_last_q;

	logic               adv;
	logic               emit;
	logic               last_pix;
	logic [REM_W-1:0]   rem_sum;
	logic               rem_wrap;

	assign adv      = !out_valid_q || pop;
	assign emit     = active_q && adv;
	assign last_pix = (pix_q == PIX_W'(PIXELS - 1));
	assign cmd_pop  = !cmd_empty && (!active_q || (emit && last_pix));

	assign rem_sum  = rem_q + REM_W'(BASE_REM);
	assign rem_wrap = (rem_sum >= REM_W'(PIXELS));

	assign empty       = !out_valid_q;
	assign pixel_index = out_idx_q;
	assign grb_color   = out_color_q;
	assign frame_last  = out_last_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			out_idx_q   <= IDX_W'(pix_q);
			out_color_q <= wheel_grb(base_q + hue_q);
			out_last_q  <= last_pix;
		end
		if (cmd_pop) begin
			hue_q  <= cmd_hue;
			pix_q  <= '0;
			base_q <= '0;
			rem_q  <= '0;
		end else if (emit) begin
			pix_q  <= pix_q + PIX_W'(1);
			base_q <= base_q + CHAN_W'(BASE_STEP) + CHAN_W'(rem_wrap);
			rem_q  <= rem_wrap ? (rem_sum - REM_W'(PIXELS)) : rem_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= active_q;
			end
			if (cmd_pop) begin
				active_q <= 1'b1;
			end else if (emit && last_pix) begin
				active_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/rainbow_cycle_led_pattern.sv =====
// Top level of the rainbow cycle frame generator: front, command queue and pixel back end.
// Path: a frame's first pixel goes via the command queue, frame registers and output register.
// Throughput: one tick item per cycle while the command queue has room; an updating tick yields
// PIXELS results from the back end's single pixel walker, one per cycle while pop drains them.
// Reset (arst_n low) clears the timer, hue, queue and output, and restores frame_wait to 10.
module rainbow_cycle_led_pattern import rcl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [TS_W-1:0]    timestamp,
	output logic               empty,
	input  logic               pop,
	output logic [IDX_W-1:0]   pixel_index,
	output logic [COLOR_W-1:0] grb_color,
	output logic               frame_last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [WAIT_W-1:0]  frame_wait
);

	frame_cmd_t cmd;
	logic       accept;
	logic       cmdq_empty;
	logic       cmdq_pop;
	hue_t       cmdq_hue;

	// Take ticks whenever the queue can absorb a frame command.
	assign accept    = push && !full;
	// Config register is always writable.
	assign cfg_ready = 1'b1;

	rcl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.timestamp (timestamp),
		.cfg_write (cfg_valid),
		.cfg_wait  (frame_wait),
		.cmd       (cmd)
	);

	// Decouple tick handling from the pixel walk.
	rcl_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (cmd),
		.pop      (cmdq_pop),
		.full     (full),
		.empty    (cmdq_empty),
		.head_hue (cmdq_hue)
	);

	// Emit one pixel per cycle into the output register while pop drains it.
	rcl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_empty   (cmdq_empty),
		.cmd_hue     (cmdq_hue),
		.cmd_pop     (cmdq_pop),
		.empty       (empty),
		.pop         (pop),
		.pixel_index (pixel_index),
		.grb_color   (grb_color),
		.frame_last  (frame_last)
	);

endmodule
